// File: hw/rtl/rru_pkg.sv
`timescale 1ns / 1ps

package rru_pkg;

    localparam int ARCH_REGS   = 32;
    localparam int PHYS_REGS   = 64;
    localparam int CHECKPOINTS = 4;

    // widths of the interface fields
    localparam int OPC_W      = 3;
    localparam int ARCH_IN_W  = 5;
    localparam int PHYS_IN_W  = 6;
    localparam int STATUS_W   = 2;
    localparam int MASK_W     = 4;

    // internal widths
    localparam int AW   = $clog2(ARCH_REGS);
    localparam int PW   = $clog2(PHYS_REGS);
    localparam int TW   = AW;
    localparam int CNTW = $clog2(PHYS_REGS + 1);
    localparam int DW   = $clog2(CHECKPOINTS + 1);
    localparam int CW   = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;

    localparam int FREE_INIT       = PHYS_REGS - ARCH_REGS;
    localparam int MASK_FULL_DEPTH = 4;
    localparam logic [MASK_W-1:0] MASK_FULL = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_DEST    = 3'd0,
        OP_BRANCH  = 3'd1,
        OP_STORE   = 3'd2,
        OP_RESTORE = 3'd3,
        OP_RELEASE = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_STALL    = 2'd1,
        ST_RESTORED = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef logic [ARCH_REGS-1:0][PW-1:0] t_map_row;

    typedef struct packed {
        logic          pop;
        logic          push;
        logic [PW-1:0] push_data;
    } t_fl_cmd;

    typedef struct packed {
        logic          empty;
        logic [PW-1:0] top;
    } t_fl_stat;

    typedef struct packed {
        logic [AW-1:0] src_a;
        logic [AW-1:0] src_b;
        logic [AW-1:0] dest;
        logic [PW-1:0] phys;
        logic          alloc;
        logic          checkpoint;
        logic          restore;
        logic          tag_adv;
    } t_map_cmd;

    typedef struct packed {
        logic [PW-1:0] src_a;
        logic [PW-1:0] src_b;
        logic [PW-1:0] old;
        logic [TW-1:0] tag;
        logic [DW-1:0] depth;
    } t_map_stat;

    // reduce a narrow register number into 0..m-1 by repeated subtraction
    function automatic logic [8:0] mod_small(input logic [7:0] v, input int unsigned m);
        logic [8:0] x;
        x = {1'b0, v};
        for (int k = 0; k < 4; k++) begin
            if (x >= 9'(m)) begin
                x = x - 9'(m);
            end
        end
        return x;
    endfunction

endpackage

// File: hw/rtl/rru_free_list.sv
`timescale 1ns / 1ps

module rru_free_list (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rru_pkg::t_fl_cmd  i_cmd,
    output rru_pkg::t_fl_stat o_stat
);

    logic [rru_pkg::PW-1:0]     r_head;
    logic [rru_pkg::PW-1:0]     n_head;
    logic [rru_pkg::CNTW-1:0]   r_count;
    logic [rru_pkg::CNTW-1:0]   n_count;
    logic [rru_pkg::CNTW:0]     w_sum;
    logic [rru_pkg::PW-1:0]     w_tail;
    logic [rru_pkg::PW-1:0]     w_head_inc;
    logic                       w_push;

    logic [rru_pkg::PW-1:0]     r_mem [rru_pkg::PHYS_REGS];
    logic [rru_pkg::PW-1:0]     r_rd_q;
    logic [rru_pkg::PW-1:0]     r_byp_data;
    logic                       r_top_byp;
    logic                       r_top_wr;
    logic [rru_pkg::PHYS_REGS-1:0] r_written;

    always_comb begin
        w_push = i_cmd.push && (r_count < rru_pkg::CNTW'(rru_pkg::PHYS_REGS));
        w_sum  = (rru_pkg::CNTW + 1)'(r_head) + (rru_pkg::CNTW + 1)'(r_count);
        if (w_sum >= (rru_pkg::CNTW + 1)'(rru_pkg::PHYS_REGS)) begin
            w_tail = rru_pkg::PW'(w_sum - (rru_pkg::CNTW + 1)'(rru_pkg::PHYS_REGS));
        end else begin
            w_tail = rru_pkg::PW'(w_sum);
        end
        if (r_head == rru_pkg::PW'(rru_pkg::PHYS_REGS - 1)) begin
            w_head_inc = '0;
        end else begin
            w_head_inc = r_head + rru_pkg::PW'(1);
        end
        n_head  = i_cmd.pop ? w_head_inc : r_head;
        n_count = r_count;
        if (i_cmd.pop) begin
            n_count = r_count - rru_pkg::CNTW'(1);
        end else if (w_push) begin
            n_count = r_count + rru_pkg::CNTW'(1);
        end
    end

    // entry at the head: a push in the previous cycle into that slot wins, then the memory,
    // then the power-up contents for slots that were never written
    always_comb begin
        o_stat.empty = (r_count == '0);
        if (r_top_byp) begin
            o_stat.top = r_byp_data;
        end else if (r_top_wr) begin
            o_stat.top = r_rd_q;
        end else begin
            o_stat.top = rru_pkg::PW'(rru_pkg::ARCH_REGS + int'(r_head));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_tail] <= i_cmd.push_data;
        end
        r_rd_q     <= r_mem[n_head];
        r_byp_data <= i_cmd.push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= rru_pkg::CNTW'(rru_pkg::FREE_INIT);
            r_written <= '0;
            r_top_byp <= 1'b0;
            r_top_wr  <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_top_byp <= w_push && (w_tail == n_head);
            r_top_wr  <= r_written[n_head];
            if (w_push) begin
                r_written[w_tail] <= 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/rru_map.sv
`timescale 1ns / 1ps

module rru_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rru_pkg::t_map_cmd  i_cmd,
    output rru_pkg::t_map_stat o_stat
);

    rru_pkg::t_map_row              r_map;
    logic [rru_pkg::PHYS_REGS-1:0]  r_busy;
    logic [rru_pkg::TW-1:0]         r_tag;
    logic [rru_pkg::DW-1:0]         r_depth;

    rru_pkg::t_map_row              r_save_map  [rru_pkg::CHECKPOINTS];
    logic [rru_pkg::PHYS_REGS-1:0]  r_save_busy [rru_pkg::CHECKPOINTS];
    logic [rru_pkg::TW-1:0]         r_save_tag  [rru_pkg::CHECKPOINTS];

    logic [rru_pkg::DW-1:0]         w_pop_depth;
    logic [rru_pkg::CW-1:0]         w_pop_slot;
    logic [rru_pkg::CW-1:0]         w_push_slot;
    logic [rru_pkg::TW-1:0]         w_tag_inc;

    always_comb begin
        w_pop_depth = r_depth - rru_pkg::DW'(1);
        w_pop_slot  = w_pop_depth[rru_pkg::CW-1:0];
        w_push_slot = r_depth[rru_pkg::CW-1:0];
        w_tag_inc   = r_tag + rru_pkg::TW'(1);
        if (w_tag_inc >= rru_pkg::TW'(rru_pkg::ARCH_REGS - 1)) begin
            w_tag_inc = '0;
        end
        o_stat.src_a = r_map[i_cmd.src_a];
        o_stat.src_b = r_map[i_cmd.src_b];
        o_stat.old   = r_map[i_cmd.dest];
        o_stat.tag   = r_tag;
        o_stat.depth = r_depth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rru_pkg::ARCH_REGS; i++) begin
                r_map[i] <= rru_pkg::PW'(i);
            end
            r_busy  <= '0;
            r_tag   <= '0;
            r_depth <= '0;
        end else begin
            if (i_cmd.restore) begin
                r_map   <= r_save_map[w_pop_slot];
                r_busy  <= r_save_busy[w_pop_slot];
                r_tag   <= r_save_tag[w_pop_slot];
                r_depth <= w_pop_depth;
            end else begin
                if (i_cmd.alloc) begin
                    r_map[i_cmd.dest]  <= i_cmd.phys;
                    r_busy[i_cmd.phys] <= 1'b1;
                end
                if (i_cmd.checkpoint) begin
                    r_depth <= r_depth + rru_pkg::DW'(1);
                end
                if (i_cmd.tag_adv) begin
                    r_tag <= w_tag_inc;
                end
            end
        end
    end

    // flash copy of the live map, busy vector and tag into the next stack slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.checkpoint) begin
            r_save_map[w_push_slot]  <= r_map;
            r_save_busy[w_push_slot] <= r_busy;
            r_save_tag[w_push_slot]  <= r_tag;
        end
    end

endmodule

// File: hw/rtl/register_rename_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    opcode, src_a/src_b/dest arch, release, issue_ready
// result    out        o_valid / i_stall    status, phys dest/src/old, entry, tag, mask
//
// One instruction per cycle while the result side does not stall; a result is valid
// after one pass from the request register through map table, free list and
// checkpoint stack into the result register.
// Synchronous active-low reset restores the identity map and the free list of
// upper registers at once; no clearing pass.
// A stall on the result side holds the request register and then stalls input.

module register_rename_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [rru_pkg::OPC_W-1:0]      i_opcode,
    input  logic [rru_pkg::ARCH_IN_W-1:0]  i_src_a_arch,
    input  logic [rru_pkg::ARCH_IN_W-1:0]  i_src_b_arch,
    input  logic [rru_pkg::ARCH_IN_W-1:0]  i_dest_arch,
    input  logic [rru_pkg::PHYS_IN_W-1:0]  i_release_phys,
    input  logic                           i_issue_ready,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rru_pkg::STATUS_W-1:0]   o_status,
    output logic [rru_pkg::PW-1:0]         o_phys_dest,
    output logic [rru_pkg::PW-1:0]         o_phys_src_a,
    output logic [rru_pkg::PW-1:0]         o_phys_src_b,
    output logic [rru_pkg::PW-1:0]         o_old_phys,
    output logic [rru_pkg::AW-1:0]         o_entry_arch,
    output logic [rru_pkg::TW-1:0]         o_active_tag,
    output logic [rru_pkg::MASK_W-1:0]     o_branch_mask
);

    logic                           r_in_valid;
    logic [rru_pkg::OPC_W-1:0]      r_in_opcode;
    logic [rru_pkg::ARCH_IN_W-1:0]  r_in_src_a;
    logic [rru_pkg::ARCH_IN_W-1:0]  r_in_src_b;
    logic [rru_pkg::ARCH_IN_W-1:0]  r_in_dest;
    logic [rru_pkg::PHYS_IN_W-1:0]  r_in_release;
    logic                           r_in_ready;

    logic                           r_out_valid;
    rru_pkg::t_status               r_out_status;
    logic [rru_pkg::PW-1:0]         r_out_phys_dest;
    logic [rru_pkg::PW-1:0]         r_out_src_a;
    logic [rru_pkg::PW-1:0]         r_out_src_b;
    logic [rru_pkg::PW-1:0]         r_out_old;
    logic [rru_pkg::AW-1:0]         r_out_entry;
    logic [rru_pkg::TW-1:0]         r_out_tag;
    logic [rru_pkg::MASK_W-1:0]     r_out_mask;

    rru_pkg::t_status               n_status;
    logic [rru_pkg::PW-1:0]         n_phys_dest;
    logic [rru_pkg::PW-1:0]         n_src_a;
    logic [rru_pkg::PW-1:0]         n_src_b;
    logic [rru_pkg::PW-1:0]         n_old;
    logic [rru_pkg::AW-1:0]         n_entry;
    logic [rru_pkg::TW-1:0]         n_tag;
    logic [rru_pkg::MASK_W-1:0]     n_mask;

    logic                           w_adv;
    logic                           w_accept;
    logic                           w_hold;
    rru_pkg::t_opcode               w_op;
    logic [rru_pkg::AW-1:0]         w_ra;
    logic [rru_pkg::AW-1:0]         w_rb;
    logic [rru_pkg::AW-1:0]         w_rd;
    logic [rru_pkg::PW-1:0]         w_rel;

    rru_pkg::t_fl_cmd               w_fl_cmd;
    rru_pkg::t_fl_stat              w_fl_stat;
    rru_pkg::t_map_cmd              w_map_cmd;
    rru_pkg::t_map_stat             w_map_stat;

    assign w_adv    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !w_adv;
    assign w_accept = i_valid && !o_stall;

    assign w_op  = rru_pkg::t_opcode'(r_in_opcode);
    assign w_ra  = rru_pkg::AW'(rru_pkg::mod_small(8'(r_in_src_a), rru_pkg::ARCH_REGS));
    assign w_rb  = rru_pkg::AW'(rru_pkg::mod_small(8'(r_in_src_b), rru_pkg::ARCH_REGS));
    assign w_rd  = rru_pkg::AW'(rru_pkg::mod_small(8'(r_in_dest), rru_pkg::ARCH_REGS));
    assign w_rel = rru_pkg::PW'(rru_pkg::mod_small(8'(r_in_release), rru_pkg::PHYS_REGS));

    always_comb begin
        n_status    = rru_pkg::ST_DONE;
        n_phys_dest = '0;
        n_src_a     = '0;
        n_src_b     = '0;
        n_old       = '0;
        n_entry     = '0;
        n_tag       = '0;
        n_mask      = '0;
        w_hold      = 1'b0;

        w_fl_cmd.pop       = 1'b0;
        w_fl_cmd.push      = 1'b0;
        w_fl_cmd.push_data = w_rel;

        w_map_cmd.src_a      = w_ra;
        w_map_cmd.src_b      = w_rb;
        w_map_cmd.dest       = w_rd;
        w_map_cmd.phys       = w_fl_stat.top;
        w_map_cmd.alloc      = 1'b0;
        w_map_cmd.checkpoint = 1'b0;
        w_map_cmd.restore    = 1'b0;
        w_map_cmd.tag_adv    = 1'b0;

        case (w_op)
            rru_pkg::OP_DEST, rru_pkg::OP_BRANCH, rru_pkg::OP_STORE: begin
                w_hold = w_fl_stat.empty || !r_in_ready ||
                         ((w_op == rru_pkg::OP_BRANCH) &&
                          (int'(w_map_stat.depth) >= rru_pkg::CHECKPOINTS));
                if (w_hold) begin
                    n_status = rru_pkg::ST_STALL;
                end else begin
                    n_src_a = w_map_stat.src_a;
                    n_src_b = w_map_stat.src_b;
                    n_old   = w_map_stat.old;
                    n_tag   = w_map_stat.tag;
                    w_map_cmd.tag_adv = w_adv;
                    if (w_op == rru_pkg::OP_DEST) begin
                        n_phys_dest     = w_fl_stat.top;
                        n_entry         = w_rd;
                        w_fl_cmd.pop    = w_adv;
                        w_map_cmd.alloc = w_adv;
                    end else begin
                        n_entry = w_rb;
                        if (w_op == rru_pkg::OP_BRANCH) begin
                            if (int'(w_map_stat.depth) >= rru_pkg::MASK_FULL_DEPTH) begin
                                n_mask = rru_pkg::MASK_FULL;
                            end else begin
                                n_mask = rru_pkg::MASK_W'(
                                    (5'd1 << w_map_stat.depth) - 5'd1);
                            end
                            w_map_cmd.checkpoint = w_adv;
                        end
                    end
                end
            end
            rru_pkg::OP_RESTORE: begin
                if (w_map_stat.depth == '0) begin
                    n_status = rru_pkg::ST_INVALID;
                end else begin
                    n_status          = rru_pkg::ST_RESTORED;
                    w_map_cmd.restore = w_adv;
                end
            end
            rru_pkg::OP_RELEASE: begin
                // a release to a full list is dropped inside the free list
                w_fl_cmd.push = w_adv;
            end
            default: begin
                n_status = rru_pkg::ST_INVALID;
            end
        endcase
    end

    rru_free_list u_free_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_fl_cmd),
        .o_stat  (w_fl_stat)
    );

    rru_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_map_cmd),
        .o_stat  (w_map_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_adv);
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_opcode  <= i_opcode;
            r_in_src_a   <= i_src_a_arch;
            r_in_src_b   <= i_src_b_arch;
            r_in_dest    <= i_dest_arch;
            r_in_release <= i_release_phys;
            r_in_ready   <= i_issue_ready;
        end
        if (w_adv) begin
            r_out_status    <= n_status;
            r_out_phys_dest <= n_phys_dest;
            r_out_src_a     <= n_src_a;
            r_out_src_b     <= n_src_b;
            r_out_old       <= n_old;
            r_out_entry     <= n_entry;
            r_out_tag       <= n_tag;
            r_out_mask      <= n_mask;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_phys_dest   = r_out_phys_dest;
    assign o_phys_src_a  = r_out_src_a;
    assign o_phys_src_b  = r_out_src_b;
    assign o_old_phys    = r_out_old;
    assign o_entry_arch  = r_out_entry;
    assign o_active_tag  = r_out_tag;
    assign o_branch_mask = r_out_mask;

    a_restore_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (n_status == rru_pkg::ST_RESTORED)) |=>
        (w_map_stat.depth == $past(w_map_stat.depth) - rru_pkg::DW'(1)))
        else $error("restore did not pop the checkpoint stack");

    a_branch_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (w_op == rru_pkg::OP_BRANCH) && (n_status == rru_pkg::ST_DONE)) |=>
        (w_map_stat.depth == $past(w_map_stat.depth) + rru_pkg::DW'(1)))
        else $error("branch did not push the checkpoint stack");

    a_alloc_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fl_cmd.pop |-> !w_fl_stat.empty)
        else $error("pop from an empty free list");

    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("renamed instruction produced no result");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ITEMS      = 1050;
    localparam int CALM_TAIL  = 120;
    localparam int MAX_REPORT = 10;
    localparam int DRAIN_CYC  = 8;
    localparam int LIMIT_NS   = 5_000_000;
    localparam logic [rru_pkg::OPC_W-1:0] OP_SPARE_LO =
        rru_pkg::OPC_W'(int'(rru_pkg::OP_RELEASE) + 1);
    localparam logic [rru_pkg::OPC_W-1:0] OP_SPARE_HI = '1;

    typedef struct packed {
        logic [rru_pkg::OPC_W-1:0]     opcode;
        logic [rru_pkg::ARCH_IN_W-1:0] src_a;
        logic [rru_pkg::ARCH_IN_W-1:0] src_b;
        logic [rru_pkg::ARCH_IN_W-1:0] dest;
        logic [rru_pkg::PHYS_IN_W-1:0] rel;
        logic                          ready;
    } t_instr;

    typedef struct packed {
        rru_pkg::t_status           status;
        logic [rru_pkg::PW-1:0]     dest;
        logic [rru_pkg::PW-1:0]     src_a;
        logic [rru_pkg::PW-1:0]     src_b;
        logic [rru_pkg::PW-1:0]     old;
        logic [rru_pkg::AW-1:0]     entry;
        logic [rru_pkg::TW-1:0]     tag;
        logic [rru_pkg::MASK_W-1:0] mask;
    } t_rename;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [rru_pkg::OPC_W-1:0]      i_opcode;
    logic [rru_pkg::ARCH_IN_W-1:0]  i_src_a_arch;
    logic [rru_pkg::ARCH_IN_W-1:0]  i_src_b_arch;
    logic [rru_pkg::ARCH_IN_W-1:0]  i_dest_arch;
    logic [rru_pkg::PHYS_IN_W-1:0]  i_release_phys;
    logic                           i_issue_ready;
    logic                           o_valid;
    logic                           i_stall;
    logic [rru_pkg::STATUS_W-1:0]   o_status;
    logic [rru_pkg::PW-1:0]         o_phys_dest;
    logic [rru_pkg::PW-1:0]         o_phys_src_a;
    logic [rru_pkg::PW-1:0]         o_phys_src_b;
    logic [rru_pkg::PW-1:0]         o_old_phys;
    logic [rru_pkg::AW-1:0]         o_entry_arch;
    logic [rru_pkg::TW-1:0]         o_active_tag;
    logic [rru_pkg::MASK_W-1:0]     o_branch_mask;

    register_rename_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_src_a_arch   (i_src_a_arch),
        .i_src_b_arch   (i_src_b_arch),
        .i_dest_arch    (i_dest_arch),
        .i_release_phys (i_release_phys),
        .i_issue_ready  (i_issue_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_phys_dest    (o_phys_dest),
        .o_phys_src_a   (o_phys_src_a),
        .o_phys_src_b   (o_phys_src_b),
        .o_old_phys     (o_old_phys),
        .o_entry_arch   (o_entry_arch),
        .o_active_tag   (o_active_tag),
        .o_branch_mask  (o_branch_mask)
    );

    always #10 i_clk = ~i_clk;

    // renamer state as seen from outside
    rru_pkg::t_map_row               map_tbl;
    logic [rru_pkg::PHYS_REGS-1:0]   busy_vec;
    logic [rru_pkg::PW-1:0]          free_ring [rru_pkg::PHYS_REGS];
    int                              free_hd;
    int                              free_cnt;
    int                              tag_ctr;
    rru_pkg::t_map_row               ckpt_map  [rru_pkg::CHECKPOINTS];
    logic [rru_pkg::PHYS_REGS-1:0]   ckpt_busy [rru_pkg::CHECKPOINTS];
    int                              ckpt_tag  [rru_pkg::CHECKPOINTS];
    int                              ckpt_depth;

    t_instr   instr_stream[$];
    t_rename  rename_backlog[$];
    t_instr   cur;
    int       sent;
    int       checked;
    int       fault_cnt;
    int       gap_left;
    int       stall_left;
    int       status_seen [4];
    int       tag_wraps;

    function automatic t_rename rename_step(t_instr in);
        t_rename r;
        int      ra;
        int      rb;
        int      rd;
        int      fr;
        int      d;
        bit      hold;
        r  = '0;
        ra = int'(in.src_a) % rru_pkg::ARCH_REGS;
        rb = int'(in.src_b) % rru_pkg::ARCH_REGS;
        rd = int'(in.dest) % rru_pkg::ARCH_REGS;
        if (in.opcode <= rru_pkg::OP_STORE) begin
            hold = (free_cnt == 0) || !in.ready ||
                   (in.opcode == rru_pkg::OP_BRANCH && ckpt_depth >= rru_pkg::CHECKPOINTS);
            if (hold) begin
                r.status = rru_pkg::ST_STALL;
            end else begin
                r.status = rru_pkg::ST_DONE;
                r.src_a  = map_tbl[ra];
                r.src_b  = map_tbl[rb];
                r.old    = map_tbl[rd];
                r.tag    = rru_pkg::TW'(tag_ctr);
                if (in.opcode == rru_pkg::OP_DEST) begin
                    fr           = int'(free_ring[free_hd]);
                    free_hd      = (free_hd + 1) % rru_pkg::PHYS_REGS;
                    free_cnt     = free_cnt - 1;
                    busy_vec[fr] = 1'b1;
                    map_tbl[rd]  = rru_pkg::PW'(fr);
                    r.dest       = rru_pkg::PW'(fr);
                    r.entry      = rru_pkg::AW'(rd);
                end else begin
                    r.entry = rru_pkg::AW'(rb);
                    if (in.opcode == rru_pkg::OP_BRANCH) begin
                        d      = ckpt_depth;
                        r.mask = (d >= rru_pkg::MASK_FULL_DEPTH) ? rru_pkg::MASK_FULL :
                                 rru_pkg::MASK_W'((1 << d) - 1);
                        ckpt_map[d]  = map_tbl;
                        ckpt_busy[d] = busy_vec;
                        ckpt_tag[d]  = tag_ctr;
                        ckpt_depth   = d + 1;
                    end
                end
                tag_ctr = tag_ctr + 1;
                if (tag_ctr >= rru_pkg::ARCH_REGS - 1) begin
                    tag_ctr   = 0;
                    tag_wraps = tag_wraps + 1;
                end
            end
        end else if (in.opcode == rru_pkg::OP_RESTORE) begin
            if (ckpt_depth == 0) begin
                r.status = rru_pkg::ST_INVALID;
            end else begin
                d          = ckpt_depth - 1;
                map_tbl    = ckpt_map[d];
                busy_vec   = ckpt_busy[d];
                tag_ctr    = ckpt_tag[d];
                ckpt_depth = d;
                r.status   = rru_pkg::ST_RESTORED;
            end
        end else if (in.opcode == rru_pkg::OP_RELEASE) begin
            // a full free list drops the register
            if (free_cnt < rru_pkg::PHYS_REGS) begin
                free_ring[(free_hd + free_cnt) % rru_pkg::PHYS_REGS] =
                    rru_pkg::PW'(int'(in.rel) % rru_pkg::PHYS_REGS);
                free_cnt = free_cnt + 1;
            end
            r.status = rru_pkg::ST_DONE;
        end else begin
            r.status = rru_pkg::ST_INVALID;
        end
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            fault_cnt++;
            if (fault_cnt <= MAX_REPORT) begin
                $display("%0t: result %0d field %s: expected %0d, got %0d",
                         $realtime, checked, name, want, got);
            end
        end
    endfunction

    task automatic push_instr(logic [rru_pkg::OPC_W-1:0] op, int a, int b, int d, int rel,
                              bit rdy);
        t_instr it;
        it.opcode = op;
        it.src_a  = rru_pkg::ARCH_IN_W'(a);
        it.src_b  = rru_pkg::ARCH_IN_W'(b);
        it.dest   = rru_pkg::ARCH_IN_W'(d);
        it.rel    = rru_pkg::PHYS_IN_W'(rel);
        it.ready  = rdy;
        instr_stream = {instr_stream, it};
    endtask

    task automatic push_random(logic [rru_pkg::OPC_W-1:0] op);
        push_instr(op, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                   $urandom_range(0, 9) != 0);
    endtask

    task automatic build_random();
        int n;
        int k;
        while (instr_stream.size() < ITEMS) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    repeat (20) begin
                        k = $urandom_range(0, 19);
                        if (k < 8)       push_random(rru_pkg::OP_DEST);
                        else if (k < 11) push_random(rru_pkg::OP_STORE);
                        else if (k < 13) push_random(rru_pkg::OP_BRANCH);
                        else if (k < 15) push_random(rru_pkg::OP_RESTORE);
                        else if (k < 19) push_random(rru_pkg::OP_RELEASE);
                        else             push_random(rru_pkg::OPC_W'(
                                             $urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
                    end
                end
                // run the free list dry
                2: repeat ($urandom_range(20, 40)) push_random(rru_pkg::OP_DEST);
                // fill it back up, past full at times
                3: repeat ($urandom_range(10, 40)) push_random(rru_pkg::OP_RELEASE);
                // nested speculation, then unwind it
                4: begin
                    n = $urandom_range(1, rru_pkg::CHECKPOINTS + 1);
                    repeat (n) begin
                        push_random(rru_pkg::OP_BRANCH);
                        repeat ($urandom_range(0, 4))
                            push_random($urandom_range(0, 1) ? rru_pkg::OP_DEST :
                                                               rru_pkg::OP_STORE);
                    end
                    repeat ($urandom_range(1, n + 1)) begin
                        push_random(rru_pkg::OP_RESTORE);
                        if ($urandom_range(0, 1)) push_random(rru_pkg::OP_DEST);
                    end
                end
                default: repeat (10)
                    push_random(rru_pkg::OPC_W'($urandom_range(0, OP_SPARE_HI)));
            endcase
        end
    endtask

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                rename_backlog = {rename_backlog, rename_step(cur)};
                sent++;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (instr_stream.size() == 0) begin
                i_valid <= 1'b0;
            end else if (instr_stream.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 16) - 1;
                i_valid <= 1'b0;
            end else begin
                cur = instr_stream[0];
                instr_stream.delete(0);
                i_opcode       <= cur.opcode;
                i_src_a_arch   <= cur.src_a;
                i_src_b_arch   <= cur.src_b;
                i_dest_arch    <= cur.dest;
                i_release_phys <= cur.rel;
                i_issue_ready  <= cur.ready;
                i_valid        <= 1'b1;
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_rename want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                checked++;
                if (rename_backlog.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= MAX_REPORT)
                        $display("%0t: result %0d arrived with none outstanding",
                                 $realtime, checked);
                end else begin
                    want = rename_backlog[0];
                    rename_backlog.delete(0);
                    check_field("status",      8'(o_status),      8'(want.status));
                    check_field("phys_dest",   8'(o_phys_dest),   8'(want.dest));
                    check_field("phys_src_a",  8'(o_phys_src_a),  8'(want.src_a));
                    check_field("phys_src_b",  8'(o_phys_src_b),  8'(want.src_b));
                    check_field("old_phys",    8'(o_old_phys),    8'(want.old));
                    check_field("entry_arch",  8'(o_entry_arch),  8'(want.entry));
                    check_field("active_tag",  8'(o_active_tag),  8'(want.tag));
                    check_field("branch_mask", 8'(o_branch_mask), 8'(want.mask));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (instr_stream.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            i_stall <= (stall_left > 0);
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_opcode       = rru_pkg::OP_DEST;
        i_src_a_arch   = '0;
        i_src_b_arch   = '0;
        i_dest_arch    = '0;
        i_release_phys = '0;
        i_issue_ready  = 1'b0;
        sent       = 0;
        checked    = 0;
        fault_cnt  = 0;
        gap_left   = 0;
        stall_left = 0;
        tag_wraps  = 0;
        status_seen = '{default: 0};

        for (int i = 0; i < rru_pkg::ARCH_REGS; i++) map_tbl[i] = rru_pkg::PW'(i);
        busy_vec = '0;
        for (int i = 0; i < rru_pkg::PHYS_REGS; i++)
            free_ring[i] = (i < rru_pkg::FREE_INIT) ? rru_pkg::PW'(rru_pkg::ARCH_REGS + i) : '0;
        free_hd    = 0;
        free_cnt   = rru_pkg::FREE_INIT;
        tag_ctr    = 0;
        ckpt_depth = 0;

        // directed opening
        push_instr(rru_pkg::OP_RESTORE, 0, 0, 0, 0, 1);
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            push_instr(rru_pkg::OPC_W'(op), rru_pkg::ARCH_REGS - 1, rru_pkg::ARCH_REGS - 1,
                       rru_pkg::ARCH_REGS - 1, rru_pkg::PHYS_REGS - 1, 1);
        push_instr(rru_pkg::OP_DEST, 0, rru_pkg::ARCH_REGS - 1, rru_pkg::ARCH_REGS - 1,
                   rru_pkg::PHYS_REGS - 1, 1);
        push_instr(rru_pkg::OP_DEST, rru_pkg::ARCH_REGS - 1, 0, 0, 0, 0);
        push_instr(rru_pkg::OP_STORE, rru_pkg::ARCH_REGS - 1, 0, rru_pkg::ARCH_REGS - 1,
                   rru_pkg::PHYS_REGS - 1, 1);
        push_instr(rru_pkg::OP_STORE, 0, rru_pkg::ARCH_REGS - 1, 0, 0, 0);
        push_instr(rru_pkg::OP_BRANCH, 1, 2, 3, 0, 0);
        // last push of the loop finds the stack full
        for (int i = 0; i <= rru_pkg::CHECKPOINTS; i++)
            push_instr(rru_pkg::OP_BRANCH, i, rru_pkg::ARCH_REGS - 1 - i,
                       rru_pkg::ARCH_REGS - 1, 0, 1);
        push_instr(rru_pkg::OP_DEST, rru_pkg::ARCH_REGS - 1, rru_pkg::ARCH_REGS - 1, 0, 0, 1);
        for (int i = 0; i <= rru_pkg::CHECKPOINTS; i++)
            push_instr(rru_pkg::OP_RESTORE, 0, 0, 0, 0, 1);
        push_instr(rru_pkg::OP_RELEASE, 0, 0, 0, rru_pkg::PHYS_REGS - 1, 1);
        push_instr(rru_pkg::OP_RELEASE, rru_pkg::ARCH_REGS - 1, rru_pkg::ARCH_REGS - 1,
                   rru_pkg::ARCH_REGS - 1, 0, 1);
        build_random();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_stream.size() > 0 || i_valid) @(posedge i_clk);
        while (rename_backlog.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("%0d instructions, %0d results checked, tag wrapped %0d times",
                 sent, checked, tag_wraps);
        $display("done %0d, stalled %0d, restored %0d, rejected %0d",
                 status_seen[rru_pkg::ST_DONE], status_seen[rru_pkg::ST_STALL],
                 status_seen[rru_pkg::ST_RESTORED], status_seen[rru_pkg::ST_INVALID]);
        if (fault_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", rename_backlog.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rru_pkg.sv
hw/rtl/rru_free_list.sv
hw/rtl/rru_map.sv
hw/rtl/register_rename_unit.sv
test/tb.sv
